// File: design/stps_pkg.sv
// ----------------------------------------------------------------------------
// stps_pkg: shared types and constants of the sum tree priority sampler
// Field widths, action codes, sequencer states and shared unit op codes.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int SLOT_W = 10;
  localparam int PRI_W  = 32;
  localparam int SUM_W  = 48;
  localparam int QSAT_W = 17;

  localparam logic [QSAT_W-1:0] Q_ONE     = 17'h10000;
  localparam logic [SLOT_W-1:0] CAP_RESET = 10'd1023;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_GET    = 2'd2;
  localparam logic [1:0] ACT_FIND   = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NORM,
    S_UP,
    S_GET,
    S_DOWN,
    S_LEAF,
    S_EMIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// File: design/stps_ifs.sv
// ----------------------------------------------------------------------------
// stps_in_if / stps_out_if: valid/ready channels of the sampler
// Request word (action and operands) and response word.
// ----------------------------------------------------------------------------
interface stps_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [stps_pkg::SLOT_W-1:0] slot_index;
  logic [stps_pkg::PRI_W-1:0]  priority_req;
  logic [stps_pkg::SUM_W-1:0]  query;
  logic                        normalize;

  modport source (output valid, action, slot_index, priority_req, query, normalize,
                  input ready);
  modport sink   (input valid, action, slot_index, priority_req, query, normalize,
                  output ready);
endinterface

interface stps_out_if;
  logic                        valid;
  logic                        ready;
  logic [stps_pkg::SLOT_W-1:0] result_slot;
  logic [stps_pkg::PRI_W-1:0]  leaf_priority;
  logic [stps_pkg::SUM_W-1:0]  total_sum;
  logic [stps_pkg::SLOT_W-1:0] fill_count;
  logic                        index_error;

  modport source (output valid, result_slot, leaf_priority, total_sum, fill_count,
                  index_error, input ready);
  modport sink   (input valid, result_slot, leaf_priority, total_sum, fill_count,
                  index_error, output ready);
endinterface

// File: design/stps_node_ram.sv
// ----------------------------------------------------------------------------
// stps_node_ram: node sum memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stps_node_ram #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/stps_alu.sv
// ----------------------------------------------------------------------------
// stps_alu: shared 48-bit add/subtract unit
// Used for leaf deltas, ancestor sums, the normalize sum and the descent
// compare; borrow and zero give the a <= b test on subtract.
// ----------------------------------------------------------------------------
module stps_alu (
  input  logic [stps_pkg::SUM_W-1:0] a,
  input  logic [stps_pkg::SUM_W-1:0] b,
  input  stps_pkg::alu_op_t          op,
  output logic [stps_pkg::SUM_W-1:0] res,
  output logic                       borrow,
  output logic                       zero
);

  logic [stps_pkg::SUM_W:0] full;

  always_comb begin
    case (op)
      stps_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default:           full = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign res    = full[stps_pkg::SUM_W-1:0];
  assign borrow = (op == stps_pkg::ALU_SUB) && full[stps_pkg::SUM_W];
  assign zero   = (res == '0);

endmodule

// File: design/sum_tree_priority_sampler_core.sv
// ----------------------------------------------------------------------------
// sum_tree_priority_sampler_core: prioritized replay sum tree
// Heap-ordered sum tree in one node memory, walked by a small sequencer
// around a shared adder/subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request word (add, update, get or find); out_ch returns
//   exactly one response word per request. cfg_we/cfg_wdata set the ring
//   capacity; write it only while no request is in flight.
// Request flow from accept to out_ch.valid (tree depth: log2 of LEAF_COUNT
// for a power of two, 10 at the default), each path ending in S_EMIT:
//   add / update : one node read-modify-write per level upward
//   find         : S_NORM if normalize is set, then one S_DOWN step per level
//   get          : leaf read in S_GET;  rejected index or zero capacity : S_EMIT
// Throughput: one request at a time; in_ch.ready rises on the same edge that
//   loads the response. The single node memory, one tree level per cycle,
//   sets the request rate.
// Reset: a clearing pass zeroes every node of the node memory with
//   in_ch.ready low; configuration writes are taken meanwhile.
// Stall: the response sits in an output register; the next request is still
//   accepted and its response waits until out_ch.ready takes the first one.
// ----------------------------------------------------------------------------
module sum_tree_priority_sampler_core #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stps_in_if.sink                     in_ch,
  stps_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [stps_pkg::SLOT_W-1:0] cfg_wdata
);

  localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
  localparam int LEAF_BASE  = LEAF_COUNT - 1;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam int CAP_LIM    = (LEAF_COUNT < 1023) ? LEAF_COUNT : 1023;
  localparam int SW         = stps_pkg::SUM_W;
  localparam int PW         = stps_pkg::PRI_W;
  localparam int LW         = stps_pkg::SLOT_W;

  localparam logic [NW-1:0] LEAF_BASE_A = NW'(LEAF_BASE);
  localparam logic [NW-1:0] LAST_NODE   = NW'(NODE_COUNT - 1);
  localparam logic [NW-1:0] ROOT_LEFT   = NW'(1);
  localparam logic [LW-1:0] CAP_LIM_V   = LW'(CAP_LIM);

  stps_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic [NW-1:0]    node_r, node_nxt;
  logic             first_r, first_nxt;
  logic [PW-1:0]    pri_r, pri_nxt;
  logic [SW-1:0]    target_r, target_nxt;
  logic [SW-1:0]    diff_r, diff_nxt;
  logic [SW-1:0]    prod_hi_r, prod_hi_nxt;
  logic [16:0]      prod_lo_r, prod_lo_nxt;
  logic [LW-1:0]    res_slot_r, res_slot_nxt;
  logic [PW-1:0]    res_pri_r, res_pri_nxt;
  logic             res_err_r, res_err_nxt;
  logic [SW-1:0]    total_r, total_nxt;
  logic [LW-1:0]    write_slot_r, write_slot_nxt;
  logic [LW-1:0]    filled_r, filled_nxt;
  logic [LW-1:0]    cap_r;
  logic             out_valid_r, out_valid_nxt;
  logic [LW-1:0]    out_slot_r, out_slot_nxt;
  logic [PW-1:0]    out_pri_r, out_pri_nxt;
  logic [SW-1:0]    out_total_r, out_total_nxt;
  logic [LW-1:0]    out_fill_r, out_fill_nxt;
  logic             out_err_r, out_err_nxt;

  logic [LW-1:0]    eff_cap;
  logic [LW-1:0]    add_slot;
  logic [LW:0]      add_inc;
  logic [NW-1:0]    add_leaf;
  logic [NW-1:0]    slot_leaf;
  logic [NW-1:0]    parent_w;
  logic [NW-1:0]    left_w;
  logic [NW-1:0]    down_next;
  logic [NW-1:0]    leaf_off;
  logic             go_left;
  logic [16:0]      qsat;
  logic [48:0]      prod_hi_w;
  logic [32:0]      prod_lo_w;
  logic [SW-1:0]    up_wdata;

  logic             ram_we;
  logic [NW-1:0]    ram_waddr;
  logic [SW-1:0]    ram_wdata;
  logic [NW-1:0]    ram_raddr;
  logic [SW-1:0]    ram_rdata;

  logic [SW-1:0]     alu_a;
  logic [SW-1:0]     alu_b;
  stps_pkg::alu_op_t alu_op;
  logic [SW-1:0]     alu_res;
  logic              alu_borrow;
  logic              alu_zero;

  stps_node_ram #(
    .DEPTH (NODE_COUNT),
    .AW    (NW),
    .DW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stps_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .res    (alu_res),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  assign eff_cap   = (cap_r > CAP_LIM_V) ? CAP_LIM_V : cap_r;
  assign add_slot  = (write_slot_r < eff_cap) ? write_slot_r : '0;
  assign add_inc   = {1'b0, add_slot} + 1'b1;
  assign add_leaf  = LEAF_BASE_A + NW'(add_slot);
  assign slot_leaf = LEAF_BASE_A + NW'(in_ch.slot_index);
  assign parent_w  = (node_r - 1'b1) >> 1;
  assign left_w    = {node_r[NW-2:0], 1'b1};
  assign go_left   = alu_borrow || alu_zero;  // target <= left sum
  assign down_next = go_left ? left_w : left_w + 1'b1;
  assign leaf_off  = node_r - LEAF_BASE_A;

  // normalized query: saturate at 1.0, split total into a 32-bit hi and a 16-bit lo part
  assign qsat      = (in_ch.query > SW'(stps_pkg::Q_ONE)) ? stps_pkg::Q_ONE
                                                          : in_ch.query[16:0];
  assign prod_hi_w = total_r[47:16] * qsat;
  assign prod_lo_w = total_r[15:0] * qsat;

  assign up_wdata  = first_r ? SW'(pri_r) : alu_res;

  assign in_ch.ready = (state_r == stps_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    node_nxt       = node_r;
    first_nxt      = first_r;
    pri_nxt        = pri_r;
    target_nxt     = target_r;
    diff_nxt       = diff_r;
    prod_hi_nxt    = prod_hi_r;
    prod_lo_nxt    = prod_lo_r;
    res_slot_nxt   = res_slot_r;
    res_pri_nxt    = res_pri_r;
    res_err_nxt    = res_err_r;
    total_nxt      = total_r;
    write_slot_nxt = write_slot_r;
    filled_nxt     = filled_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_pri_nxt    = out_pri_r;
    out_total_nxt  = out_total_r;
    out_fill_nxt   = out_fill_r;
    out_err_nxt    = out_err_r;
    ram_we         = 1'b0;
    ram_waddr      = node_r;
    ram_wdata      = up_wdata;
    ram_raddr      = '0;
    alu_a          = target_r;
    alu_b          = ram_rdata;
    alu_op         = stps_pkg::ALU_SUB;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      stps_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_NODE) begin
          state_nxt = stps_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      stps_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          pri_nxt     = in_ch.priority_req;
          target_nxt  = in_ch.query;
          prod_hi_nxt = prod_hi_w[SW-1:0];
          prod_lo_nxt = prod_lo_w[32:16];
          first_nxt   = 1'b1;
          res_err_nxt = 1'b0;
          case (in_ch.action)
            stps_pkg::ACT_ADD: begin
              if (eff_cap == '0) begin
                res_err_nxt  = 1'b1;
                res_slot_nxt = '0;
                res_pri_nxt  = '0;
                state_nxt    = stps_pkg::S_EMIT;
              end else begin
                res_slot_nxt   = add_slot;
                res_pri_nxt    = in_ch.priority_req;
                write_slot_nxt = (add_inc >= {1'b0, eff_cap}) ? '0 : add_inc[LW-1:0];
                if (filled_r < eff_cap) begin
                  filled_nxt = filled_r + 1'b1;
                end
                node_nxt  = add_leaf;
                ram_raddr = add_leaf;
                state_nxt = stps_pkg::S_UP;
              end
            end
            stps_pkg::ACT_UPDATE, stps_pkg::ACT_GET: begin
              res_slot_nxt = in_ch.slot_index;
              if (in_ch.slot_index >= eff_cap) begin
                res_err_nxt = 1'b1;
                res_pri_nxt = '0;
                state_nxt   = stps_pkg::S_EMIT;
              end else begin
                res_pri_nxt = in_ch.priority_req;
                node_nxt    = slot_leaf;
                ram_raddr   = slot_leaf;
                state_nxt   = (in_ch.action == stps_pkg::ACT_UPDATE) ? stps_pkg::S_UP
                                                                     : stps_pkg::S_GET;
              end
            end
            default: begin
              node_nxt  = '0;
              ram_raddr = ROOT_LEFT;
              state_nxt = in_ch.normalize ? stps_pkg::S_NORM : stps_pkg::S_DOWN;
            end
          endcase
        end
      end

      stps_pkg::S_NORM: begin
        alu_a      = prod_hi_r;
        alu_b      = SW'(prod_lo_r);
        alu_op     = stps_pkg::ALU_ADD;
        target_nxt = alu_res;
        ram_raddr  = ROOT_LEFT;
        state_nxt  = stps_pkg::S_DOWN;
      end

      // leaf first (write new priority, keep delta), then delta up to root
      stps_pkg::S_UP: begin
        alu_a     = first_r ? SW'(pri_r) : ram_rdata;
        alu_b     = first_r ? ram_rdata : diff_r;
        alu_op    = first_r ? stps_pkg::ALU_SUB : stps_pkg::ALU_ADD;
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = up_wdata;
        first_nxt = 1'b0;
        if (first_r) begin
          diff_nxt = alu_res;
        end
        if (node_r == '0) begin
          total_nxt = up_wdata;
          state_nxt = stps_pkg::S_EMIT;
        end else begin
          node_nxt  = parent_w;
          ram_raddr = parent_w;
        end
      end

      stps_pkg::S_GET: begin
        res_pri_nxt = ram_rdata[PW-1:0];
        state_nxt   = stps_pkg::S_EMIT;
      end

      // rdata holds the left child sum of node_r
      stps_pkg::S_DOWN: begin
        if (!go_left) begin
          target_nxt = alu_res;
        end
        node_nxt = down_next;
        if (down_next < LEAF_BASE_A) begin
          ram_raddr = {down_next[NW-2:0], 1'b1};
        end else begin
          ram_raddr = down_next;
          state_nxt = stps_pkg::S_LEAF;
        end
      end

      stps_pkg::S_LEAF: begin
        res_pri_nxt  = ram_rdata[PW-1:0];
        res_slot_nxt = LW'(leaf_off);
        res_err_nxt  = ((NW + LW)'(leaf_off) >= (NW + LW)'(eff_cap));
        state_nxt    = stps_pkg::S_EMIT;
      end

      stps_pkg::S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_pri_nxt   = res_pri_r;
          out_total_nxt = total_r;
          out_fill_nxt  = filled_r;
          out_err_nxt   = res_err_r;
          state_nxt     = stps_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = stps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stps_pkg::S_CLEAR;
      clr_r        <= '0;
      first_r      <= 1'b0;
      total_r      <= '0;
      write_slot_r <= '0;
      filled_r     <= '0;
      cap_r        <= stps_pkg::CAP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      first_r      <= first_nxt;
      total_r      <= total_nxt;
      write_slot_r <= write_slot_nxt;
      filled_r     <= filled_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    pri_r       <= pri_nxt;
    target_r    <= target_nxt;
    diff_r      <= diff_nxt;
    prod_hi_r   <= prod_hi_nxt;
    prod_lo_r   <= prod_lo_nxt;
    res_slot_r  <= res_slot_nxt;
    res_pri_r   <= res_pri_nxt;
    res_err_r   <= res_err_nxt;
    out_slot_r  <= out_slot_nxt;
    out_pri_r   <= out_pri_nxt;
    out_total_r <= out_total_nxt;
    out_fill_r  <= out_fill_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_slot   = out_slot_r;
  assign out_ch.leaf_priority = out_pri_r;
  assign out_ch.total_sum     = out_total_r;
  assign out_ch.fill_count    = out_fill_r;
  assign out_ch.index_error   = out_err_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("sampler ready again right after accepting a word");

  a_descent_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stps_pkg::S_DOWN) |=> (node_r > $past(node_r)))
    else $error("find descent did not move to a child node");

  a_walk_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stps_pkg::S_UP && node_r != '0) |=> (node_r < $past(node_r)))
    else $error("update walk did not move to the parent node");

  a_fill_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && filled_r != $past(filled_r)) |-> (filled_r == $past(filled_r) + 1'b1))
    else $error("fill count changed by other than one");
`endif

endmodule
